// ===== rtl/core/dtw_pkg.sv =====
// Shared types, codes and helpers for the DTW distance and path unit.
package dtw_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COST_W   = 32;
  localparam int LEN_W    = 5;
  localparam int IDX_W    = 4;
  localparam int ROW_W    = 5;
  localparam int REG_W    = 1;

  typedef enum logic [1:0] {
    OP_LOAD_REF = 2'd0,
    OP_LOAD_QRY = 2'd1,
    OP_START    = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [REG_W-1:0] {
    REG_REFERENCE_LENGTH = 1'b0,
    REG_QUERY_LENGTH     = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_WAVE,
    ST_BT_HERE,
    ST_BT_UP,
    ST_BT_DEC
  } state_t;

  // link between neighboring cells of the wavefront
  typedef struct packed {
    logic                valid;
    logic [ROW_W-1:0]    row;
    logic [SAMPLE_W-1:0] ref_val;
    logic [COST_W-1:0]   cost;
    logic [COST_W-1:0]   prev;
  } link_t;

  function automatic logic [COST_W-1:0] abs_diff(input logic [SAMPLE_W-1:0] a,
                                                 input logic [SAMPLE_W-1:0] b);
    logic signed [SAMPLE_W:0] d;
    d = $signed({a[SAMPLE_W-1], a}) - $signed({b[SAMPLE_W-1], b});
    if (d[SAMPLE_W]) d = -d;
    return COST_W'(d[SAMPLE_W:0]);
  endfunction

endpackage

// ===== rtl/core/dtw_if.sv =====
// Valid/ready channel interfaces for input, result and configuration items.
interface dtw_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic [dtw_pkg::IDX_W-1:0]     sample_index;
  logic signed [dtw_pkg::SAMPLE_W-1:0] sample_value;
  modport source (output valid, operation, sample_index, sample_value, input ready);
  modport sink (input valid, operation, sample_index, sample_value, output ready);
endinterface

interface dtw_out_if;
  logic                        valid;
  logic                        ready;
  logic [dtw_pkg::IDX_W-1:0]   path_row;
  logic [dtw_pkg::IDX_W-1:0]   path_col;
  logic [dtw_pkg::COST_W-1:0]  path_cost;
  logic                        path_last;
  modport source (output valid, path_row, path_col, path_cost, path_last, input ready);
  modport sink (input valid, path_row, path_col, path_cost, path_last, output ready);
endinterface

interface dtw_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [dtw_pkg::REG_W-1:0]  index;
  logic [dtw_pkg::LEN_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/dtw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dtw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/dtw_cell.sv =====
// One column cell: holds a query sample, computes its cost per row, keeps the column.
module dtw_cell #(
  parameter int MAX_LENGTH = 16,
  parameter int J          = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_we,
  input  logic [$clog2(MAX_LENGTH)-1:0]   q_idx,
  input  logic [dtw_pkg::SAMPLE_W-1:0]    q_val,
  input  dtw_pkg::link_t                  link_in,
  output dtw_pkg::link_t                  link_out,
  output logic [dtw_pkg::SAMPLE_W-1:0]    qry_val,
  input  logic [$clog2(MAX_LENGTH)-1:0]   raddr,
  output logic [dtw_pkg::COST_W-1:0]      rdata
);
  import dtw_pkg::*;

  localparam int IW = $clog2(MAX_LENGTH);
  localparam logic [IW-1:0] MY_COL = IW'(J);

  logic [SAMPLE_W-1:0] qry_r;
  logic                valid_r;
  logic [ROW_W-1:0]    row_r;
  logic [SAMPLE_W-1:0] ref_r;
  logic [COST_W-1:0]   cost_r, prev_r;
  logic [COST_W-1:0]   m, cost_nxt, lu;
  logic                row0;

  always_comb begin
    row0 = (link_in.row == '0);
    lu   = (link_in.cost < cost_r) ? link_in.cost : cost_r;
    if (row0 && J == 0)  m = '0;
    else if (row0)       m = link_in.cost;
    else if (J == 0)     m = cost_r;
    else                 m = (link_in.prev < lu) ? link_in.prev : lu;
    cost_nxt = abs_diff(link_in.ref_val, qry_r) + m;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= link_in.valid;
    end
    if (q_we && q_idx == MY_COL) qry_r <= q_val;
    if (link_in.valid) begin
      row_r  <= link_in.row;
      ref_r  <= link_in.ref_val;
      cost_r <= cost_nxt;
      prev_r <= cost_r;
    end
  end

  assign link_out = '{valid: valid_r, row: row_r, ref_val: ref_r, cost: cost_r, prev: prev_r};
  assign qry_val  = qry_r;

  dtw_ram #(.WIDTH(COST_W), .DEPTH(MAX_LENGTH)) u_col (
    .clk  (clk),
    .we   (link_in.valid),
    .waddr(link_in.row[IW-1:0]),
    .wdata(cost_nxt),
    .raddr(raddr),
    .rdata(rdata)
  );
endmodule

// ===== rtl/core/dtw_distance_and_path_unit.sv =====
// Top level: DTW cost matrix fill on a cell chain, then backtrack of the path.
//
//  channel  | dir | fields
//  ---------+-----+-------------------------------------------------
//  in_ch    | in  | operation, sample_index, sample_value
//  out_ch   | out | path_row, path_col, path_cost, path_last
//  cfg_ch   | in  | index (0 reference_length, 1 query_length), data
//
// A start runs the wavefront down the chain of MAX_LENGTH column cells, then
// walks the path back with two reads of the column RAMs and a decision for
// each path point.
// Reset is synchronous, active low; no clearing pass. in_ch.ready is low while
// a start is in progress; a stalled out_ch holds the backtrack at its decision.
module dtw_distance_and_path_unit #(
  parameter int MAX_LENGTH = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  dtw_in_if.sink  in_ch,
  dtw_out_if.source out_ch,
  dtw_cfg_if.sink cfg_ch
);
  import dtw_pkg::*;

  localparam int IW = $clog2(MAX_LENGTH);
  localparam int LW = $clog2(MAX_LENGTH + 1);

  state_t state_r, state_nxt;

  logic [LEN_W-1:0] ref_len_r, qry_len_r;
  logic [LW-1:0]    rl_eff, ql_eff;
  logic [IW-1:0]    rl_m1, ql_m1;

  logic [IW-1:0]       cnt_r, i_r, j_r, jm1;
  logic [COST_W-1:0]   here_r, d_r;
  logic                feed_v_r;
  logic [IW-1:0]       feed_row_r;

  logic                in_acc, idx_ok, ref_we, q_we, emit, slot_free, at_end;
  logic [IW-1:0]       ref_raddr, cell_raddr;
  logic [SAMPLE_W-1:0] ref_rd;

  link_t               link [MAX_LENGTH+1];
  logic [SAMPLE_W-1:0] qv   [MAX_LENGTH];
  logic [COST_W-1:0]   rd   [MAX_LENGTH];

  logic                out_valid_r, out_last_r;
  logic [IDX_W-1:0]    out_row_r, out_col_r;
  logic [COST_W-1:0]   out_cost_r;
  logic [COST_W-1:0]   diag, up;

  // configuration
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_len_r <= LEN_W'(16);
      qry_len_r <= LEN_W'(16);
    end else if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_REFERENCE_LENGTH: ref_len_r <= cfg_ch.data;
        REG_QUERY_LENGTH:     qry_len_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ref_len_r == '0)                 rl_eff = LW'(1);
    else if (32'(ref_len_r) > MAX_LENGTH) rl_eff = LW'(MAX_LENGTH);
    else                                 rl_eff = LW'(ref_len_r);
    if (qry_len_r == '0)                 ql_eff = LW'(1);
    else if (32'(qry_len_r) > MAX_LENGTH) ql_eff = LW'(MAX_LENGTH);
    else                                 ql_eff = LW'(qry_len_r);
  end
  assign rl_m1 = IW'(rl_eff - LW'(1));
  assign ql_m1 = IW'(ql_eff - LW'(1));

  // input decode
  assign in_acc = in_ch.valid && in_ch.ready;
  assign idx_ok = 32'(in_ch.sample_index) < MAX_LENGTH;
  assign ref_we = in_acc && op_t'(in_ch.operation) == OP_LOAD_REF && idx_ok;
  assign q_we   = in_acc && op_t'(in_ch.operation) == OP_LOAD_QRY && idx_ok;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign at_end    = (i_r == '0) && (j_r == '0);
  assign jm1       = j_r - IW'(1);
  assign diag      = rd[jm1];
  assign up        = rd[j_r];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_acc && op_t'(in_ch.operation) == OP_START) state_nxt = ST_FILL;
      ST_FILL:    if (cnt_r == rl_m1) state_nxt = ST_WAVE;
      ST_WAVE:    if (link[MAX_LENGTH].valid && link[MAX_LENGTH].row[IW-1:0] == rl_m1)
                    state_nxt = ST_BT_HERE;
      ST_BT_HERE: state_nxt = ST_BT_UP;
      ST_BT_UP:   state_nxt = ST_BT_DEC;
      ST_BT_DEC:  if (slot_free) state_nxt = at_end ? ST_IDLE : ST_BT_HERE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    ref_raddr   = (state_r == ST_FILL) ? cnt_r : i_r;
    cell_raddr  = (state_r == ST_BT_HERE) ? i_r : i_r - IW'(1);
    emit        = (state_r == ST_BT_DEC) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      feed_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      feed_v_r <= (state_r == ST_FILL);
      if (emit)                           out_valid_r <= 1'b1;
      else if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
    end
    feed_row_r <= cnt_r;
    if (state_r == ST_IDLE)      cnt_r <= '0;
    else if (state_r == ST_FILL) cnt_r <= cnt_r + IW'(1);
    if (state_r == ST_WAVE) begin
      i_r <= rl_m1;
      j_r <= ql_m1;
    end
    if (state_r == ST_BT_UP) begin
      here_r <= rd[j_r];
      d_r    <= abs_diff(ref_rd, qv[j_r]);
    end
    if (emit) begin
      out_row_r  <= IDX_W'(i_r);
      out_col_r  <= IDX_W'(j_r);
      out_cost_r <= here_r;
      out_last_r <= at_end;
      if (i_r == '0)                j_r <= jm1;
      else if (j_r == '0)           i_r <= i_r - IW'(1);
      else if (diag + d_r == here_r) begin
        i_r <= i_r - IW'(1);
        j_r <= jm1;
      end else if (up + d_r == here_r) i_r <= i_r - IW'(1);
      else                          j_r <= jm1;
    end
  end

  dtw_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LENGTH)) u_ref (
    .clk  (clk),
    .we   (ref_we),
    .waddr(IW'(in_ch.sample_index)),
    .wdata(in_ch.sample_value),
    .raddr(ref_raddr),
    .rdata(ref_rd)
  );

  assign link[0] = '{valid: feed_v_r, row: ROW_W'(feed_row_r), ref_val: ref_rd,
                     cost: '0, prev: '0};

  for (genvar g = 0; g < MAX_LENGTH; g++) begin : g_cell
    dtw_cell #(.MAX_LENGTH(MAX_LENGTH), .J(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .q_we    (q_we),
      .q_idx   (IW'(in_ch.sample_index)),
      .q_val   (in_ch.sample_value),
      .link_in (link[g]),
      .link_out(link[g+1]),
      .qry_val (qv[g]),
      .raddr   (cell_raddr),
      .rdata   (rd[g])
    );
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.path_row  = out_row_r;
  assign out_ch.path_col  = out_col_r;
  assign out_ch.path_cost = out_cost_r;
  assign out_ch.path_last = out_last_r;
endmodule

// ===== rtl/core/dtw_checker.sv =====
// Port-level checks of the DTW unit, bound to the top level.
module dtw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_operation,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_row,
  input logic [3:0]  out_col,
  input logic [31:0] out_cost,
  input logic        out_last
);
  import dtw_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
      && $stable(out_cost) && $stable(out_last))
    else $error("stalled result item changed");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_START |=> !in_ready)
    else $error("input ready right after start");

  a_last_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_row == '0 && out_col == '0)
    else $error("path end not at origin");

  a_mid_path_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready before path finished");
endmodule

bind dtw_distance_and_path_unit dtw_checker u_dtw_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_operation(in_ch.operation),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_row     (out_ch.path_row),
  .out_col     (out_ch.path_col),
  .out_cost    (out_ch.path_cost),
  .out_last    (out_ch.path_last)
);

// ===== bench/dtw_tb_if.sv =====
`timescale 1ns / 100ps
// Testbench item types for input items and expected path points.
package dtw_tb_pkg;
  import dtw_pkg::*;

  typedef struct packed {
    op_t               op;
    logic [3:0]        idx;
    logic [15:0]       val;
  } dtw_item_t;

  typedef struct packed {
    logic [3:0]  row;
    logic [3:0]  col;
    logic [31:0] cost;
    logic        last;
  } path_point_t;
endpackage

// ===== bench/tb_dtw_distance_and_path_unit.sv =====
`timescale 1ns / 100ps
// Testbench for dtw_distance_and_path_unit: directed table, random loads and starts, path check.
module tb_dtw_distance_and_path_unit;
  import dtw_pkg::*;
  import dtw_tb_pkg::*;

  localparam int LEN_MAX = 16;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  dtw_in_if  in_ch ();
  dtw_out_if out_ch ();
  dtw_cfg_if cfg_ch ();

  dtw_distance_and_path_unit #(.MAX_LENGTH(LEN_MAX)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  logic [15:0] ref_samples [LEN_MAX];
  logic [15:0] qry_samples [LEN_MAX];
  logic [31:0] acc_cost [LEN_MAX][LEN_MAX];
  logic [4:0]  ref_len_reg, qry_len_reg;
  path_point_t path_queue [$];
  int mismatches = 0;
  int points_seen = 0;
  int starts_sent = 0;
  int idle_cycles = 0;
  logic timed_out = 1'b0;

  function automatic int clamp_len(logic [4:0] raw);
    if (raw == 0) return 1;
    if (raw > LEN_MAX) return LEN_MAX;
    return raw;
  endfunction

  function automatic logic [31:0] sample_dist(int i, int j);
    int a, b;
    a = $signed(ref_samples[i]);
    b = $signed(qry_samples[j]);
    return (a >= b) ? a - b : b - a;
  endfunction

  task automatic predict_item(dtw_item_t it);
    int rl, ql, i, j;
    logic [31:0] m, d;
    path_point_t p;
    case (it.op)
      OP_LOAD_REF: ref_samples[it.idx] = it.val;
      OP_LOAD_QRY: qry_samples[it.idx] = it.val;
      OP_START: begin
        rl = clamp_len(ref_len_reg);
        ql = clamp_len(qry_len_reg);
        for (i = 0; i < rl; i++)
          for (j = 0; j < ql; j++) begin
            if (i == 0 && j == 0) m = 0;
            else if (i == 0) m = acc_cost[0][j-1];
            else if (j == 0) m = acc_cost[i-1][0];
            else begin
              m = acc_cost[i-1][j] < acc_cost[i][j-1] ? acc_cost[i-1][j] : acc_cost[i][j-1];
              if (acc_cost[i-1][j-1] < m) m = acc_cost[i-1][j-1];
            end
            acc_cost[i][j] = sample_dist(i, j) + m;
          end
        i = rl - 1;
        j = ql - 1;
        while (i != 0 || j != 0) begin
          d = sample_dist(i, j);
          p = '{row: 4'(i), col: 4'(j), cost: acc_cost[i][j], last: 1'b0};
          path_queue.push_back(p);
          if (i == 0) j--;
          else if (j == 0) i--;
          else if (acc_cost[i-1][j-1] + d == acc_cost[i][j]) begin
            i--; j--;
          end else if (acc_cost[i-1][j] + d == acc_cost[i][j]) i--;
          else j--;
        end
        path_queue.push_back('{row: 4'd0, col: 4'd0, cost: acc_cost[0][0], last: 1'b1});
      end
      default: ;
    endcase
  endtask

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
           ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
  endfunction

  // result side: random stall, compare against oldest expected point
  initial begin
    path_point_t exp_p;
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      stall = ($urandom_range(0, 3) == 0) ? short_gap() : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      points_seen++;
      if (path_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected point row %0d col %0d cost %0d",
                                       out_ch.path_row, out_ch.path_col, out_ch.path_cost);
      end else begin
        exp_p = path_queue.pop_front();
        if (out_ch.path_row !== exp_p.row || out_ch.path_col !== exp_p.col ||
            out_ch.path_cost !== exp_p.cost || out_ch.path_last !== exp_p.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("point mismatch: exp %0d,%0d,%0d,%0d got %0d,%0d,%0d,%0d",
                     exp_p.row, exp_p.col, exp_p.cost, exp_p.last, out_ch.path_row,
                     out_ch.path_col, out_ch.path_cost, out_ch.path_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && idle_cycles > WATCHDOG) timed_out <= 1'b1;
  end

  // valid stays high into the next call; a gap in the next call, write_len or drain drops it
  task automatic send_item(dtw_item_t it);
    int gap;
    gap = short_gap();
    cfg_ch.valid <= 1'b0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.operation    <= it.op;
    in_ch.sample_index <= it.idx;
    in_ch.sample_value <= it.val;
    in_ch.valid        <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_item(it);
    if (it.op == OP_START) starts_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid  <= 1'b0;
    cfg_ch.valid <= 1'b0;
    while (path_queue.size() != 0) @(negedge clk);
    repeat (3 * LEN_MAX + 40) @(negedge clk);
  endtask

  task automatic write_len(reg_idx_t r, logic [4:0] v);
    in_ch.valid  <= 1'b0;
    cfg_ch.index <= r;
    cfg_ch.data  <= v;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (r == REG_REFERENCE_LENGTH) ref_len_reg = v;
    else qry_len_reg = v;
    @(negedge clk);
  endtask

  task automatic load_all(bit extreme);
    int k;
    logic [15:0] v;
    for (k = 0; k < LEN_MAX; k++) begin
      v = extreme ? (k[0] ? 16'h8000 : 16'h7fff) : 16'($urandom);
      send_item('{op: OP_LOAD_REF, idx: 4'(k), val: v});
      v = extreme ? (k[1] ? 16'h7fff : 16'h8000) : 16'($urandom);
      send_item('{op: OP_LOAD_QRY, idx: 4'(k), val: v});
    end
  endtask

  // directed rows: lengths and an item; small-value rows are read straight off
  typedef struct {
    logic [4:0] rl;
    logic [4:0] ql;
    dtw_item_t  it;
  } dir_row_t;

  dir_row_t dir_rows [] = '{
    '{5'd16, 5'd16, '{OP_START,    4'd0,  16'h0}},
    '{5'd1,  5'd1,  '{OP_START,    4'd0,  16'h0}},
    '{5'd0,  5'd0,  '{OP_START,    4'd0,  16'h0}},
    '{5'd31, 5'd31, '{OP_START,    4'd0,  16'h0}},
    '{5'd1,  5'd16, '{OP_START,    4'd0,  16'h0}},
    '{5'd16, 5'd1,  '{OP_START,    4'd0,  16'h0}},
    '{5'd3,  5'd5,  '{OP_NONE,     4'd7,  16'hffff}},
    '{5'd3,  5'd5,  '{OP_START,    4'd0,  16'h0}},
    '{5'd2,  5'd2,  '{OP_LOAD_REF, 4'd15, 16'h0000}},
    '{5'd2,  5'd2,  '{OP_LOAD_QRY, 4'd0,  16'h1234}},
    '{5'd2,  5'd2,  '{OP_START,    4'd0,  16'h0}}
  };

  initial begin
    dtw_item_t it;
    int n, k;
    in_ch.valid = 1'b0; in_ch.operation = OP_NONE;
    in_ch.sample_index = '0; in_ch.sample_value = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = REG_REFERENCE_LENGTH; cfg_ch.data = '0;
    ref_len_reg = 5'd16; qry_len_reg = 5'd16;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    fork
      begin
        // single cell with zero samples: one point, cost 0
        send_item('{op: OP_LOAD_REF, idx: 4'd0, val: 16'h0});
        send_item('{op: OP_LOAD_QRY, idx: 4'd0, val: 16'h0});
        write_len(REG_REFERENCE_LENGTH, 5'd1);
        write_len(REG_QUERY_LENGTH, 5'd1);
        path_queue.delete();
        send_item('{op: OP_START, idx: 4'd0, val: 16'h0});
        path_queue.delete();
        path_queue.push_back('{row: 4'd0, col: 4'd0, cost: 32'd0, last: 1'b1});
        drain();
        // full-scale extremes: (0,0) distance 65535
        load_all(1);
        write_len(REG_REFERENCE_LENGTH, 5'd1);
        write_len(REG_QUERY_LENGTH, 5'd1);
        send_item('{op: OP_START, idx: 4'd0, val: 16'h0});
        if (path_queue[0].cost !== 32'd65535) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table cost for extreme cell: exp 65535 got %0d", path_queue[0].cost);
        end
        drain();
        foreach (dir_rows[r]) begin
          write_len(REG_REFERENCE_LENGTH, dir_rows[r].rl);
          write_len(REG_QUERY_LENGTH, dir_rows[r].ql);
          send_item(dir_rows[r].it);
          drain();
        end
        load_all(0);
        // random phases
        n = 0;
        while (n < 400) begin
          write_len(REG_REFERENCE_LENGTH, ($urandom_range(0, 5) == 0) ?
                    5'($urandom_range(0, 31)) : 5'($urandom_range(1, 6)));
          write_len(REG_QUERY_LENGTH, ($urandom_range(0, 5) == 0) ?
                    5'($urandom_range(0, 31)) : 5'($urandom_range(1, 6)));
          for (k = 0; k < 12; k++) begin
            it.op  = op_t'(($urandom_range(0, 15) == 0) ? 3 : $urandom_range(0, 2));
            it.idx = 4'($urandom);
            it.val = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15) - 8);
            send_item(it);
            n++;
          end
          drain();
        end
      end
      begin
        wait (timed_out);
      end
    join_any
    disable fork;

    if (timed_out) begin
      $display("** dtw_distance_and_path_unit: FAILED **");
      $finish;
    end else begin
      $display("covered %0d starts and %0d path points, lengths 1..16 and clamped",
               starts_sent, points_seen);
      if (mismatches == 0 && path_queue.size() == 0) $display("** dtw_distance_and_path_unit: PASSED **");
      else $display("** dtw_distance_and_path_unit: FAILED **");
      $finish;
    end
  end
endmodule

// ===== dtw_distance_and_path_unit.f =====
rtl/core/dtw_pkg.sv
rtl/core/dtw_if.sv
rtl/core/dtw_ram.sv
rtl/core/dtw_cell.sv
rtl/core/dtw_distance_and_path_unit.sv
rtl/core/dtw_checker.sv
bench/dtw_tb_if.sv
bench/tb_dtw_distance_and_path_unit.sv
